// ----- sv/psd_pkg.sv -----
package psd_pkg;

  localparam int unsigned COORD_WIDTH_DEF     = 16;
  localparam int unsigned ALPHA_FRAC_BITS_DEF = 16;
  localparam int unsigned DIST_WIDTH          = 51;

  // front end stages plus back end stages; the divider adds one stage per alpha bit
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned BACK_STAGES  = 6;
  localparam int unsigned PIPE_FIXED   = FRONT_STAGES + BACK_STAGES;

  // sideband that travels with each beat
  typedef struct packed {
    logic valid;
    logic degen;
    logic sat;
  } ctl_t;

endpackage

// ----- sv/psd_front.sv -----
module psd_front #(
  parameter int unsigned COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic signed [COORD_WIDTH-1:0]   query_x_i,
  input  logic signed [COORD_WIDTH-1:0]   query_y_i,
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   end_y_i,
  output psd_pkg::ctl_t                   ctl_o,
  output logic [2*COORD_WIDTH:0]          tsqr_o,
  output logic [2*COORD_WIDTH:0]          rem_o,
  output logic signed [COORD_WIDTH:0]     px_o,
  output logic signed [COORD_WIDTH:0]     py_o,
  output logic signed [COORD_WIDTH:0]     tx_o,
  output logic signed [COORD_WIDTH:0]     ty_o
);
  import psd_pkg::*;

  localparam int unsigned D_W   = COORD_WIDTH + 1;
  localparam int unsigned PRD_W = 2 * D_W;
  localparam int unsigned TSQ_W = 2 * COORD_WIDTH + 1;

  // stage 1: differences
  logic                  v1_q;
  logic signed [D_W-1:0] tx1_q, ty1_q, px1_q, py1_q;
  // stage 2: products
  logic                    v2_q;
  logic signed [PRD_W-1:0] txx2_q, tyy2_q, pxt2_q, pyt2_q;
  logic signed [D_W-1:0]   tx2_q, ty2_q, px2_q, py2_q;
  // stage 3: sums
  logic                    v3_q;
  logic signed [PRD_W-1:0] tsqr_full, dot_d;
  logic [TSQ_W-1:0]        tsqr3_q;
  logic signed [PRD_W-1:0] dot3_q;
  logic signed [D_W-1:0]   tx3_q, ty3_q, px3_q, py3_q;
  // stage 4: clamp decision
  ctl_t                    ctl_d, ctl_q;
  logic                    dot_pos, dot_ge;
  logic [TSQ_W-1:0]        rem_d, rem_q, tsqr4_q;
  logic signed [D_W-1:0]   tx4_q, ty4_q, px4_q, py4_q;

  assign tsqr_full = txx2_q + tyy2_q;
  assign dot_d     = pxt2_q + pyt2_q;

  // a positive dot product is below 2^TSQ_W and compares as unsigned
  assign dot_pos = !dot3_q[PRD_W-1] && (dot3_q != '0);
  assign dot_ge  = dot3_q[TSQ_W-1:0] >= tsqr3_q;

  always_comb begin
    ctl_d.valid = v3_q;
    ctl_d.degen = (tsqr3_q == '0);
    ctl_d.sat   = dot_pos && dot_ge;
    rem_d       = (dot_pos && !dot_ge) ? dot3_q[TSQ_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      ctl_q <= '0;
    end else begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx1_q   <= D_W'(end_x_i) - D_W'(start_x_i);
    ty1_q   <= D_W'(end_y_i) - D_W'(start_y_i);
    px1_q   <= D_W'(query_x_i) - D_W'(start_x_i);
    py1_q   <= D_W'(query_y_i) - D_W'(start_y_i);

    txx2_q  <= PRD_W'(tx1_q) * PRD_W'(tx1_q);
    tyy2_q  <= PRD_W'(ty1_q) * PRD_W'(ty1_q);
    pxt2_q  <= PRD_W'(px1_q) * PRD_W'(tx1_q);
    pyt2_q  <= PRD_W'(py1_q) * PRD_W'(ty1_q);
    tx2_q   <= tx1_q;
    ty2_q   <= ty1_q;
    px2_q   <= px1_q;
    py2_q   <= py1_q;

    tsqr3_q <= tsqr_full[TSQ_W-1:0];
    dot3_q  <= dot_d;
    tx3_q   <= tx2_q;
    ty3_q   <= ty2_q;
    px3_q   <= px2_q;
    py3_q   <= py2_q;

    rem_q   <= rem_d;
    tsqr4_q <= tsqr3_q;
    tx4_q   <= tx3_q;
    ty4_q   <= ty3_q;
    px4_q   <= px3_q;
    py4_q   <= py3_q;
  end

  assign ctl_o  = ctl_q;
  assign tsqr_o = tsqr4_q;
  assign rem_o  = rem_q;
  assign px_o   = px4_q;
  assign py_o   = py4_q;
  assign tx_o   = tx4_q;
  assign ty_o   = ty4_q;

endmodule

// ----- sv/psd_div.sv -----
module psd_div #(
  parameter int unsigned COORD_WIDTH     = psd_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ALPHA_FRAC_BITS = psd_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psd_pkg::ctl_t                     ctl_i,
  input  logic [2*COORD_WIDTH:0]            tsqr_i,
  input  logic [2*COORD_WIDTH:0]            rem_i,
  input  logic signed [COORD_WIDTH:0]       px_i,
  input  logic signed [COORD_WIDTH:0]       py_i,
  input  logic signed [COORD_WIDTH:0]       tx_i,
  input  logic signed [COORD_WIDTH:0]       ty_i,
  output psd_pkg::ctl_t                     ctl_o,
  output logic [ALPHA_FRAC_BITS-1:0]        quot_o,
  output logic signed [COORD_WIDTH:0]       px_o,
  output logic signed [COORD_WIDTH:0]       py_o,
  output logic signed [COORD_WIDTH:0]       tx_o,
  output logic signed [COORD_WIDTH:0]       ty_o
);
  import psd_pkg::*;

  localparam int unsigned D_W   = COORD_WIDTH + 1;
  localparam int unsigned TSQ_W = 2 * COORD_WIDTH + 1;
  localparam int unsigned F     = ALPHA_FRAC_BITS;

  ctl_t                  ctl_q  [F];
  logic [TSQ_W-1:0]      rem_q  [F];
  logic [TSQ_W-1:0]      tsqr_q [F];
  logic [F-1:0]          quot_q [F];
  logic signed [D_W-1:0] px_q   [F];
  logic signed [D_W-1:0] py_q   [F];
  logic signed [D_W-1:0] tx_q   [F];
  logic signed [D_W-1:0] ty_q   [F];

  // one restoring step per stage, one quotient bit per stage
  for (genvar k = 0; k < F; k++) begin : g_stage
    ctl_t                  ctl_in;
    logic [TSQ_W-1:0]      rem_in, tsqr_in;
    logic [F-1:0]          quot_in;
    logic signed [D_W-1:0] px_in, py_in, tx_in, ty_in;
    logic [TSQ_W:0]        rem2, diff;
    logic                  ge;

    if (k == 0) begin : g_head
      assign ctl_in  = ctl_i;
      assign rem_in  = rem_i;
      assign tsqr_in = tsqr_i;
      assign quot_in = '0;
      assign px_in   = px_i;
      assign py_in   = py_i;
      assign tx_in   = tx_i;
      assign ty_in   = ty_i;
    end else begin : g_body
      assign ctl_in  = ctl_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign tsqr_in = tsqr_q[k-1];
      assign quot_in = quot_q[k-1];
      assign px_in   = px_q[k-1];
      assign py_in   = py_q[k-1];
      assign tx_in   = tx_q[k-1];
      assign ty_in   = ty_q[k-1];
    end

    assign rem2 = {rem_in, 1'b0};
    assign diff = rem2 - {1'b0, tsqr_in};
    assign ge   = rem2 >= {1'b0, tsqr_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[TSQ_W-1:0] : rem2[TSQ_W-1:0];
      quot_q[k] <= {quot_in[F-2:0], ge};
      tsqr_q[k] <= tsqr_in;
      px_q[k]   <= px_in;
      py_q[k]   <= py_in;
      tx_q[k]   <= tx_in;
      ty_q[k]   <= ty_in;
    end
  end

  assign ctl_o  = ctl_q[F-1];
  assign quot_o = quot_q[F-1];
  assign px_o   = px_q[F-1];
  assign py_o   = py_q[F-1];
  assign tx_o   = tx_q[F-1];
  assign ty_o   = ty_q[F-1];

endmodule

// ----- sv/psd_back.sv -----
module psd_back #(
  parameter int unsigned COORD_WIDTH     = psd_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ALPHA_FRAC_BITS = psd_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psd_pkg::ctl_t                       ctl_i,
  input  logic [ALPHA_FRAC_BITS-1:0]          quot_i,
  input  logic signed [COORD_WIDTH:0]         px_i,
  input  logic signed [COORD_WIDTH:0]         py_i,
  input  logic signed [COORD_WIDTH:0]         tx_i,
  input  logic signed [COORD_WIDTH:0]         ty_i,
  output logic                                done_o,
  output logic [psd_pkg::DIST_WIDTH-1:0]      dist_sqr_o,
  output logic                                degenerate_o
);
  import psd_pkg::*;

  localparam int unsigned F     = ALPHA_FRAC_BITS;
  localparam int unsigned D_W   = COORD_WIDTH + 1;
  localparam int unsigned PR_W  = COORD_WIDTH + F + 3;
  localparam int unsigned DX_W  = COORD_WIDTH + F + 2;
  localparam int unsigned M     = DX_W - 1;
  localparam int unsigned LO_W  = (M + 1) / 2;
  localparam int unsigned HI_W  = M - LO_W;
  localparam int unsigned SQ_W  = 2 * M;
  localparam int unsigned SUM_W = SQ_W + 1;
  localparam int unsigned EXT_W = (SUM_W > DIST_WIDTH) ? SUM_W : DIST_WIDTH + 1;
  localparam int unsigned SH    = 2 * F - 16;

  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;

  // b1: alpha times t
  logic [F:0]             alpha;
  logic signed [F+1:0]    alpha_s;
  logic signed [PR_W-1:0] pax1_q, pay1_q;
  logic signed [D_W-1:0]  px1_q, py1_q;

  assign alpha   = ctl_i.sat ? (F+1)'(1) << F : {1'b0, quot_i};
  assign alpha_s = $signed({1'b0, alpha});

  // b2: offset from closest point, scaled by 2^F
  logic signed [PR_W-1:0] dx_full, dy_full;
  logic signed [DX_W-1:0] dx2_q, dy2_q;

  assign dx_full = (PR_W'(px1_q) <<< F) - pax1_q;
  assign dy_full = (PR_W'(py1_q) <<< F) - pay1_q;

  // b3: magnitudes
  logic signed [DX_W-1:0] dx_neg, dy_neg;
  logic [M-1:0]           mx3_q, my3_q;

  assign dx_neg = -dx2_q;
  assign dy_neg = -dy2_q;

  // b4: partial products of each square
  logic [2*LO_W-1:0]      xll4_q, yll4_q;
  logic [LO_W+HI_W-1:0]   xlh4_q, ylh4_q;
  logic [2*HI_W-1:0]      xhh4_q, yhh4_q;

  // b5: squares
  logic [SQ_W-1:0]        sqx5_q, sqy5_q;

  // b6: sum, scale and saturate
  logic [SUM_W-1:0]       sum;
  logic [EXT_W-1:0]       scaled;
  logic                   ovf;
  logic                   done_q, degen_q;
  logic [DIST_WIDTH-1:0]  dist_d, dist_q;

  assign sum    = SUM_W'(sqx5_q) + SUM_W'(sqy5_q);
  assign scaled = EXT_W'(sum) >> SH;
  assign ovf    = |scaled[EXT_W-1:DIST_WIDTH];
  assign dist_d = (ctl5_q.degen || ovf) ? '1 : scaled[DIST_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      done_q <= ctl5_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pax1_q  <= PR_W'(tx_i) * PR_W'(alpha_s);
    pay1_q  <= PR_W'(ty_i) * PR_W'(alpha_s);
    px1_q   <= px_i;
    py1_q   <= py_i;

    dx2_q   <= dx_full[DX_W-1:0];
    dy2_q   <= dy_full[DX_W-1:0];

    mx3_q   <= dx2_q[DX_W-1] ? dx_neg[M-1:0] : dx2_q[M-1:0];
    my3_q   <= dy2_q[DX_W-1] ? dy_neg[M-1:0] : dy2_q[M-1:0];

    xll4_q  <= (2*LO_W)'(mx3_q[LO_W-1:0]) * (2*LO_W)'(mx3_q[LO_W-1:0]);
    xlh4_q  <= (LO_W+HI_W)'(mx3_q[LO_W-1:0]) * (LO_W+HI_W)'(mx3_q[M-1:LO_W]);
    xhh4_q  <= (2*HI_W)'(mx3_q[M-1:LO_W]) * (2*HI_W)'(mx3_q[M-1:LO_W]);
    yll4_q  <= (2*LO_W)'(my3_q[LO_W-1:0]) * (2*LO_W)'(my3_q[LO_W-1:0]);
    ylh4_q  <= (LO_W+HI_W)'(my3_q[LO_W-1:0]) * (LO_W+HI_W)'(my3_q[M-1:LO_W]);
    yhh4_q  <= (2*HI_W)'(my3_q[M-1:LO_W]) * (2*HI_W)'(my3_q[M-1:LO_W]);

    // cross term appears twice in a square
    sqx5_q  <= (SQ_W'(xhh4_q) << (2 * LO_W)) + (SQ_W'(xlh4_q) << (LO_W + 1))
               + SQ_W'(xll4_q);
    sqy5_q  <= (SQ_W'(yhh4_q) << (2 * LO_W)) + (SQ_W'(ylh4_q) << (LO_W + 1))
               + SQ_W'(yll4_q);

    dist_q  <= dist_d;
    degen_q <= ctl5_q.degen;
  end

  assign done_o       = done_q;
  assign dist_sqr_o   = dist_q;
  assign degenerate_o = degen_q;

endmodule

// ----- sv/point_segment_distance_sqr_top.sv -----
// Squared distance from a query point to a line segment, fixed point. Pulse
// start_i with the six coordinates; busy_o is always low, so a new beat can be
// issued on every clock. Each beat comes back as a one-cycle done_o pulse with
// dist_sqr_o (units of 1/65536, truncated) and degenerate_o, in issue order.
// The receiver cannot stall: done_o must be sampled on the cycle it is high.
// The pipeline runs four stages of difference/dot-product setup, then the
// projection divider, which resolves one alpha bit per pipeline stage, then
// six stages of distance arithmetic. A zero-length segment returns all ones
// with degenerate_o set.
module point_segment_distance_sqr_top #(
  parameter int unsigned COORD_WIDTH     = psd_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ALPHA_FRAC_BITS = psd_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [COORD_WIDTH-1:0]    query_x_i,
  input  logic signed [COORD_WIDTH-1:0]    query_y_i,
  input  logic signed [COORD_WIDTH-1:0]    start_x_i,
  input  logic signed [COORD_WIDTH-1:0]    start_y_i,
  input  logic signed [COORD_WIDTH-1:0]    end_x_i,
  input  logic signed [COORD_WIDTH-1:0]    end_y_i,
  output logic                             done_o,
  output logic [psd_pkg::DIST_WIDTH-1:0]   dist_sqr_o,
  output logic                             degenerate_o
);
  import psd_pkg::*;

  localparam int unsigned D_W   = COORD_WIDTH + 1;
  localparam int unsigned TSQ_W = 2 * COORD_WIDTH + 1;

  // fully pipelined with no back-pressure, so the block is never busy
  assign busy_o = 1'b0;

  // front end -> divider
  ctl_t                  f_ctl;
  logic [TSQ_W-1:0]      f_tsqr, f_rem;
  logic signed [D_W-1:0] f_px, f_py, f_tx, f_ty;

  // divider -> back end
  ctl_t                     d_ctl;
  logic [ALPHA_FRAC_BITS-1:0] d_quot;
  logic signed [D_W-1:0]    d_px, d_py, d_tx, d_ty;

  // t = end - start, p = query - start, |t|^2, p.t, and the clamp decision:
  // p.t <= 0 feeds a zero remainder (alpha 0), p.t >= |t|^2 marks saturation
  psd_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start_i && !busy_o),
    .query_x_i  (query_x_i),
    .query_y_i  (query_y_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .ctl_o      (f_ctl),
    .tsqr_o     (f_tsqr),
    .rem_o      (f_rem),
    .px_o       (f_px),
    .py_o       (f_py),
    .tx_o       (f_tx),
    .ty_o       (f_ty)
  );

  // restoring division, one quotient bit per stage: floor(2^F * p.t / |t|^2)
  psd_div #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (f_ctl),
    .tsqr_i (f_tsqr),
    .rem_i  (f_rem),
    .px_i   (f_px),
    .py_i   (f_py),
    .tx_i   (f_tx),
    .ty_i   (f_ty),
    .ctl_o  (d_ctl),
    .quot_o (d_quot),
    .px_o   (d_px),
    .py_o   (d_py),
    .tx_o   (d_tx),
    .ty_o   (d_ty)
  );

  // d = p*2^F - t*alpha per axis, squared via split partial products,
  // summed, scaled down by 2^(2F-16) and saturated to the result width
  psd_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (d_ctl),
    .quot_i       (d_quot),
    .px_i         (d_px),
    .py_i         (d_py),
    .tx_i         (d_tx),
    .ty_i         (d_ty),
    .done_o       (done_o),
    .dist_sqr_o   (dist_sqr_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ----- sv/psd_chk.sv -----
module psd_chk #(
  parameter int unsigned COORD_WIDTH     = psd_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ALPHA_FRAC_BITS = psd_pkg::ALPHA_FRAC_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [COORD_WIDTH-1:0]         query_x_i,
  input logic [COORD_WIDTH-1:0]         query_y_i,
  input logic [COORD_WIDTH-1:0]         start_x_i,
  input logic [COORD_WIDTH-1:0]         start_y_i,
  input logic [COORD_WIDTH-1:0]         end_x_i,
  input logic [COORD_WIDTH-1:0]         end_y_i,
  input logic                           done_o,
  input logic [psd_pkg::DIST_WIDTH-1:0] dist_sqr_o,
  input logic                           degenerate_o
);
  import psd_pkg::*;

  localparam int unsigned LAT = PIPE_FIXED + ALPHA_FRAC_BITS;

  // every accepted beat returns after the fixed latency
  a_beat_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o)
    else $error("accepted beat did not return");

  // no result without a beat accepted the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching beat");

  // zero-length segment reports degenerate with all ones
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (start_x_i == end_x_i) && (start_y_i == end_y_i)
    |-> ##LAT (degenerate_o && (&dist_sqr_o)))
    else $error("zero-length segment not flagged");

  // query on the start point of a real segment is at distance zero
  a_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (query_x_i == start_x_i) && (query_y_i == start_y_i)
    && ((start_x_i != end_x_i) || (start_y_i != end_y_i))
    |-> ##LAT (!degenerate_o && (dist_sqr_o == '0)))
    else $error("query at start point gave nonzero distance");

endmodule

bind point_segment_distance_sqr_top psd_chk #(
  .COORD_WIDTH     (COORD_WIDTH),
  .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
) u_psd_chk (.*);
